// ----- src/fsd_pkg.sv -----
// fsd_pkg: shared types and codes for the selective-dequeue queue
// operation and status codes, command struct and the links between cells
// no dependencies
package fsd_pkg;

   localparam int CODE_W = 8;

   // operation codes on req_mode
   typedef enum logic [1:0] {
      MODE_ENQ         = 2'd0,
      MODE_TAKE_OLDEST = 2'd1,
      MODE_TAKE_MATCH  = 2'd2,
      MODE_RSVD        = 2'd3
   } fsd_mode_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_APPENDED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_NONE     = 2'd2,
      ST_FULL     = 2'd3
   } fsd_status_type;

   // command broadcast to every cell, already qualified by the transfer
   typedef struct packed {
      logic              enq;
      logic              take_any;
      logic              take_match;
      logic [CODE_W-1:0] code;
   } fsd_cmd_type;

   // link from an older cell to its younger neighbor
   typedef struct packed {
      logic              hit;    // some cell at or before this one is removed
      logic [CODE_W-1:0] value;  // code of the removed entry
      logic              valid;  // this cell holds an entry
   } fsd_link_type;

   // contents of one cell, handed to its older neighbor
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } fsd_slot_type;

endpackage

// ----- src/fsd_cell.sv -----
// fsd_cell: one queue slot with its compare and shift logic
// passes the removal prefix forward and takes its younger neighbor's entry on removal
// depends on fsd_pkg
module fsd_cell
   import fsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  fsd_cmd_type  cmd,
   input  fsd_link_type link_in,
   output fsd_link_type link_out,
   input  fsd_slot_type younger,
   output fsd_slot_type slot
);

   logic              valid_ff, valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              hit_here;
   logic              shift;

   // compare and removal prefix
   always_comb begin
      hit_here = valid_ff && (cmd.take_any || (cmd.take_match && code_ff == cmd.code));
      shift    = link_in.hit || hit_here;
      link_out.hit   = shift;
      link_out.value = link_in.hit ? link_in.value : (hit_here ? code_ff : '0);
      link_out.valid = valid_ff;
      slot.valid = valid_ff;
      slot.code  = code_ff;
   end

   // next contents: close the gap or accept an append
   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (shift) begin
         valid_in = younger.valid;
         code_in  = younger.code;
      end else if (cmd.enq && !valid_ff && link_in.valid) begin
         valid_in = 1'b1;
         code_in  = cmd.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

endmodule

// ----- src/fifo_with_selective_dequeue_core.sv -----
// fifo_with_selective_dequeue_core: ordered queue with oldest and oldest-match removal
// response valid the cycle after a request transfer; one op per cycle unless rsp stalls
// the compare and removal-prefix ripple through the row of DEPTH cells sets the clock path
// synchronous active-high reset empties the queue and drops any pending response
// depends on fsd_pkg and fsd_cell
module fifo_with_selective_dequeue_core
   import fsd_pkg::*;
#(
   parameter int DEPTH = 16
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_item_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_value,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic              accept;
   fsd_cmd_type       cmd;
   fsd_link_type      link [0:DEPTH];
   fsd_slot_type      slot [0:DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              full;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_value_ff, rsp_value_in;
   fsd_status_type    rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff;

   // request side: take a transfer whenever the response slot frees up
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));

   // command broadcast to the cells
   always_comb begin
      cmd.enq        = accept && (req_mode == MODE_ENQ);
      cmd.take_any   = accept && (req_mode == MODE_TAKE_OLDEST);
      cmd.take_match = accept && (req_mode == MODE_TAKE_MATCH);
      cmd.code       = req_item_value;
   end

   // ends of the chain: a virtual full cell before the oldest, an empty one after the youngest
   assign link[0] = '{hit: 1'b0, value: '0, valid: 1'b1};
   assign slot[DEPTH] = '{valid: 1'b0, code: '0};

   // row of cells, oldest first
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      fsd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .link_in  (link[k]),
         .link_out (link[k+1]),
         .younger  (slot[k+1]),
         .slot     (slot[k])
      );
   end

   // count and response contents
   always_comb begin
      count_in      = count_ff;
      rsp_value_in  = '0;
      rsp_status_in = ST_NONE;
      if (cmd.enq) begin
         if (full) begin
            rsp_status_in = ST_FULL;
         end else begin
            rsp_status_in = ST_APPENDED;
            count_in      = count_ff + CNT_W'(1);
         end
      end else if (link[DEPTH].hit) begin
         rsp_status_in = ST_REMOVED;
         rsp_value_in  = link[DEPTH].value;
         count_in      = count_ff - CNT_W'(1);
      end
      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = 5'(rsp_count_ff);

endmodule

// ----- tb/sv/fsd_checker.sv -----
`timescale 1ns / 1ps
// fsd_checker: passive checker for the selective-dequeue queue core
// mirrors the queue contents, predicts every reply and compares it field by field
// depends on fsd_pkg
module fsd_checker
   import fsd_pkg::*;
#(
   parameter int DEPTH = 16
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_item_value,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_value,
   input  logic [1:0] rsp_status,
   input  logic [4:0] rsp_occupancy,
   output int         fail_count,
   output int         replies_owed
);

   typedef struct packed {
      logic [7:0]     value;
      fsd_status_type status;
      logic [4:0]     occupancy;
   } reply_type;

   // mirror of the queue, oldest code at the front
   logic [7:0] queued_codes[$];
   // replies predicted but not yet seen on the response channel
   reply_type  owed_replies[$];

   // apply one operation to the mirror and return the reply it should give
   function automatic reply_type predict_queue_op(fsd_mode_type mode, logic [7:0] code);
      reply_type r;
      int        k;
      bit        found;
      r.value  = '0;
      r.status = ST_NONE;
      found    = 1'b0;
      case (mode)
         MODE_ENQ: begin
            if (queued_codes.size() < DEPTH) begin
               queued_codes.push_back(code);
               r.status = ST_APPENDED;
            end else begin
               r.status = ST_FULL;
            end
         end
         MODE_TAKE_OLDEST: begin
            if (queued_codes.size() > 0) begin
               r.value  = queued_codes.pop_front();
               r.status = ST_REMOVED;
            end
         end
         MODE_TAKE_MATCH: begin
            // oldest equal entry goes, the rest keep their order
            for (k = 0; k < queued_codes.size() && !found; k++) begin
               if (queued_codes[k] == code) begin
                  r.value  = queued_codes[k];
                  r.status = ST_REMOVED;
                  queued_codes.delete(k);
                  found    = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.occupancy = 5'(queued_codes.size());
      return r;
   endfunction

   // one line per mismatch
   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count = fail_count + 1;
   endtask

   // predict on request transfers, compare on response transfers
   always @(posedge clock) begin : watch_transfers
      reply_type want;
      if (reset) begin
         queued_codes.delete();
         owed_replies.delete();
      end else begin
         if (req_valid && req_ready)
            owed_replies.push_back(predict_queue_op(fsd_mode_type'(req_mode), req_item_value));
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               report_mismatch("reply transfer with no request outstanding");
            end else begin
               want = owed_replies.pop_front();
               if (rsp_out_value !== want.value)
                  report_mismatch($sformatf("out_value got %0d want %0d",
                                            rsp_out_value, want.value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status code got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy got %0d want %0d",
                                            rsp_occupancy, want.occupancy));
            end
         end
      end
      replies_owed <= owed_replies.size();
   end

endmodule

// ----- tb/sv/tb_fifo_with_selective_dequeue_core.sv -----
`timescale 1ns / 1ps
// tb_fifo_with_selective_dequeue_core: stimulus, clocking and verdict for the queue core
// directed corner cases then biased random traffic with idle bursts on both sides
// depends on fsd_pkg, fifo_with_selective_dequeue_core and fsd_checker
module tb_fifo_with_selective_dequeue_core
   import fsd_pkg::*;
;

   localparam int QUEUE_DEPTH = 16;
   localparam int STALL_LIMIT = 3000;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode       = MODE_ENQ;
   logic [7:0] req_item_value = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_out_value;
   logic [1:0] rsp_status;
   logic [4:0] rsp_occupancy;

   int fail_count;
   int replies_owed;
   int quiet_cycles = 0;
   int stall_left   = 0;
   bit idle_on      = 1'b1;

   fifo_with_selective_dequeue_core #(.DEPTH(QUEUE_DEPTH)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   fsd_checker #(.DEPTH(QUEUE_DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_value  (rsp_out_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .fail_count     (fail_count),
      .replies_owed   (replies_owed)
   );

   always #1 clock = ~clock;

   // response side backpressure in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // offer one operation, with an optional idle burst first, and wait for its transfer
   task automatic send_op(input fsd_mode_type mode, input logic [7:0] code);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_item_value <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold off requests until every predicted reply has been seen
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_owed != 0) @(posedge clock);
   endtask

   initial begin
      int              blk;
      int              n;
      int              k;
      int              enq_pct;
      int              r;
      bit              narrow;
      logic [7:0]      base;
      logic [7:0]      code;
      fsd_mode_type    mode;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty queue: both removals miss, reserved mode does nothing
      send_op(MODE_TAKE_OLDEST, 8'h00);
      send_op(MODE_TAKE_MATCH, 8'h00);
      send_op(MODE_RSVD, 8'hFF);
      // fill to the top with a duplicate code as the youngest entry
      for (k = 0; k < QUEUE_DEPTH - 1; k++)
         send_op(MODE_ENQ, 8'(k * 17));
      send_op(MODE_ENQ, 8'h55);
      // full queue drops the code
      send_op(MODE_ENQ, 8'hFF);
      // older of the two equal codes goes first, then a miss
      send_op(MODE_TAKE_MATCH, 8'h55);
      send_op(MODE_TAKE_MATCH, 8'hFF);
      send_op(MODE_ENQ, 8'hFF);
      send_op(MODE_TAKE_OLDEST, 8'hAA);
      // match on the youngest entry
      send_op(MODE_TAKE_MATCH, 8'hFF);

      // random blocks biased toward filling or draining, no idling near the end
      for (blk = 0; blk < 42; blk++) begin
         idle_on <= (blk < 37) && ($urandom_range(0, 3) != 0);
         if (blk == 20)
            drain_replies();
         enq_pct = $urandom_range(20, 80);
         narrow  = ($urandom_range(0, 3) != 0);
         base    = 8'($urandom_range(0, 255)) & 8'hF8;
         for (n = 0; n < 40; n++) begin
            r    = $urandom_range(0, 99);
            // a narrow code set makes matches likely
            code = narrow ? (base | 8'($urandom_range(0, 7))) : 8'($urandom_range(0, 255));
            if (r < 3)
               mode = MODE_RSVD;
            else if (r < 3 + enq_pct)
               mode = MODE_ENQ;
            else if ($urandom_range(0, 2) == 0)
               mode = MODE_TAKE_OLDEST;
            else
               mode = MODE_TAKE_MATCH;
            send_op(mode, code);
         end
      end

      drain_replies();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- fifo_with_selective_dequeue_core.f -----
src/fsd_pkg.sv
src/fsd_cell.sv
src/fifo_with_selective_dequeue_core.sv
tb/sv/fsd_checker.sv
tb/sv/tb_fifo_with_selective_dequeue_core.sv
